### src/gsa_pkg.sv
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Sizes, field widths, operation and status codes shared by the allocator
// and its channel interfaces.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int SLOTS        = 64;
  localparam int GEN_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Channel field widths
  localparam int KIND_W       = 2;
  localparam int SLOT_FIELD_W = 7;
  localparam int GEN_FIELD_W  = 16;
  localparam int PAY_FIELD_W  = 32;
  localparam int STATUS_W     = 2;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef logic [IDX_W-1:0]        slot_idx_t;
  typedef logic [GEN_BITS-1:0]     gen_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // One free-list entry: the slot and the generation it will hand out
  typedef struct packed {
    gen_t      gen;
    slot_idx_t idx;
  } free_ent_t;

  function automatic slot_idx_t next_pos(input slot_idx_t p);
    slot_idx_t r;
    if (p == slot_idx_t'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = p + slot_idx_t'(1);
    end
    return r;
  endfunction

endpackage

### src/gsa_if.sv
// ----------------------------------------------------------------------------
// Generational slot allocator channels
// Request and result channels with valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface gsa_in_if import gsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [SLOT_FIELD_W-1:0] slot_index;
  logic [GEN_FIELD_W-1:0]  generation;
  logic [PAY_FIELD_W-1:0]  payload;

  modport source (output valid, kind, slot_index, generation, payload, input ready);
  modport sink   (input valid, kind, slot_index, generation, payload, output ready);
endinterface

interface gsa_out_if import gsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_FIELD_W-1:0] handle_index;
  logic [GEN_FIELD_W-1:0]  handle_generation;
  logic [PAY_FIELD_W-1:0]  found_payload;

  modport source (output valid, status, handle_index, handle_generation, found_payload,
                  input ready);
  modport sink   (input valid, status, handle_index, handle_generation, found_payload,
                  output ready);
endinterface

### src/generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// Generational slot allocator
// Handle table with per-slot generation, occupancy and payload, plus a free
// list of slot indices. Allocate, release and lookup, one result per request.
// ----------------------------------------------------------------------------
// Stages: request transfer into execute, then the result register on out_ch.
// Throughput: one request per cycle unless out_ch stalls; the table reads are
//   launched at request transfer and the state update happens in the single execute stage.
// Reset (synchronous, rst_n low): all slots free and empty, free list holds
//   slots 0..SLOTS-1 in order, generations zero. No clearing pass is needed:
//   per-entry valid bits stand in for the reset contents of the tables.
module generational_slot_allocator import gsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gsa_in_if.sink    in_ch,
  gsa_out_if.source out_ch
);

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  // Free list: each entry carries the slot and the generation it will hand
  // out, so an allocate needs no second, dependent read of the generation table.
  free_ent_t         free_mem [SLOTS];
  logic [SLOTS-1:0]  free_vld_r;     // entry written since reset
  gen_t              gen_mem  [SLOTS];
  logic [SLOTS-1:0]  gen_vld_r;      // unwritten generation reads as zero
  pay_t              val_mem  [SLOTS];
  logic [SLOTS-1:0]  slot_used_r;

  slot_idx_t head_r, head_nxt;
  slot_idx_t tail_r, tail_nxt;
  cnt_t      fifo_count_r, fifo_count_nxt;

  // Execute stage: request register plus registered table reads
  logic                    s1_vld_r, s1_vld_nxt;
  logic [KIND_W-1:0]       s1_kind_r;
  logic [SLOT_FIELD_W-1:0] s1_slot_r;
  logic [GEN_FIELD_W-1:0]  s1_gen_r;
  pay_t                    s1_pay_r;
  free_ent_t               fifo_rd_r;
  gen_t                    gen_rd_r;
  pay_t                    val_rd_r;

  // Result register
  logic                    out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0]     out_status_r;
  logic [SLOT_FIELD_W-1:0] out_idx_r;
  logic [GEN_FIELD_W-1:0]  out_gen_r;
  logic [PAY_FIELD_W-1:0]  out_pay_r;

  // --------------------------------------------------------------------------
  // Handshake: the result register parts the two sides
  // --------------------------------------------------------------------------
  logic advance, s1_fire, in_fire;

  assign advance  = !out_vld_r || out_ch.ready;
  assign s1_fire  = s1_vld_r && advance;
  assign in_ch.ready = !s1_vld_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign s1_vld_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = s1_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  // --------------------------------------------------------------------------
  // Execute: decide the outcome from the registered request and reads
  // --------------------------------------------------------------------------
  logic                    in_range, used, gen_match;
  slot_idx_t               s1_sidx;
  logic                    do_pop, do_rel;
  logic [STATUS_W-1:0]     res_status;
  logic [SLOT_FIELD_W-1:0] res_idx;
  logic [GEN_FIELD_W-1:0]  res_gen;
  logic [PAY_FIELD_W-1:0]  res_pay;

  assign in_range  = s1_slot_r < SLOT_FIELD_W'(SLOTS);
  assign s1_sidx   = s1_slot_r[IDX_W-1:0];
  assign used      = slot_used_r[s1_sidx];
  assign gen_match = gen_rd_r == s1_gen_r[GEN_BITS-1:0];

  always_comb begin
    res_status = ST_OK;
    res_idx    = s1_slot_r;
    res_gen    = s1_gen_r;
    res_pay    = '0;
    do_pop     = 1'b0;
    do_rel     = 1'b0;
    case (s1_kind_r)
      KIND_ALLOC: begin
        if (fifo_count_r == '0) begin
          res_status = ST_FULL;
          res_idx    = SLOT_FIELD_W'(SLOTS);
          res_gen    = '0;
        end else begin
          do_pop  = 1'b1;
          res_idx = SLOT_FIELD_W'(fifo_rd_r.idx);
          res_gen = GEN_FIELD_W'(fifo_rd_r.gen);
        end
      end
      KIND_RELEASE, KIND_LOOKUP: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else if (!used || !gen_match) begin
          res_status = ST_STALE;
        end else if (s1_kind_r == KIND_LOOKUP) begin
          res_pay = PAY_FIELD_W'(val_rd_r);
        end else begin
          do_rel = 1'b1;
        end
      end
      default: begin
        // unused operation code: reject as a bad request
        res_status = ST_RANGE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State update on execute
  // --------------------------------------------------------------------------
  logic      pop, rel, push;
  gen_t      gen_bumped;
  free_ent_t push_ent;

  assign pop        = s1_fire && do_pop;
  assign rel        = s1_fire && do_rel;
  assign push       = rel && (fifo_count_r < CNT_W'(SLOTS));
  assign gen_bumped = gen_rd_r + gen_t'(1);
  assign push_ent   = '{gen: gen_bumped, idx: s1_sidx};

  assign head_nxt = pop  ? next_pos(head_r) : head_r;
  assign tail_nxt = push ? next_pos(tail_r) : tail_r;

  always_comb begin
    fifo_count_nxt = fifo_count_r;
    if (pop && !push) begin
      fifo_count_nxt = fifo_count_r - cnt_t'(1);
    end else if (push && !pop) begin
      fifo_count_nxt = fifo_count_r + cnt_t'(1);
    end
  end

  // Read addresses for the request being taken now; the head already
  // reflects a pop by the request leaving execute in this cycle
  slot_idx_t rd_slot;
  assign rd_slot = in_ch.slot_index[IDX_W-1:0];

  // Memories: write on execute, read on request transfer with bypass of
  // the write landing at the same edge
  always_ff @(posedge clk) begin
    if (rel) begin
      gen_mem[s1_sidx] <= gen_bumped;
    end
    if (pop) begin
      val_mem[fifo_rd_r.idx] <= s1_pay_r;
    end
    if (push) begin
      free_mem[tail_r] <= push_ent;
    end
    if (in_fire) begin
      if (rel && s1_sidx == rd_slot) begin
        gen_rd_r <= gen_bumped;
      end else if (gen_vld_r[rd_slot]) begin
        gen_rd_r <= gen_mem[rd_slot];
      end else begin
        gen_rd_r <= '0;
      end
      if (pop && fifo_rd_r.idx == rd_slot) begin
        val_rd_r <= s1_pay_r;
      end else begin
        val_rd_r <= val_mem[rd_slot];
      end
      if (push && tail_r == head_nxt) begin
        fifo_rd_r <= push_ent;
      end else if (free_vld_r[head_nxt]) begin
        fifo_rd_r <= free_mem[head_nxt];
      end else begin
        fifo_rd_r <= '{gen: '0, idx: head_nxt};
      end
      s1_kind_r <= in_ch.kind;
      s1_slot_r <= in_ch.slot_index;
      s1_gen_r  <= in_ch.generation;
      s1_pay_r  <= PAYLOAD_BITS'(in_ch.payload);
    end
    if (s1_fire) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_gen_r    <= res_gen;
      out_pay_r    <= res_pay;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      fifo_count_r <= cnt_t'(SLOTS);
      free_vld_r   <= '0;
      gen_vld_r    <= '0;
      slot_used_r  <= '0;
    end else begin
      s1_vld_r     <= s1_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fifo_count_r <= fifo_count_nxt;
      if (push) begin
        free_vld_r[tail_r] <= 1'b1;
      end
      if (rel) begin
        gen_vld_r[s1_sidx]   <= 1'b1;
        slot_used_r[s1_sidx] <= 1'b0;
      end
      if (pop) begin
        slot_used_r[fifo_rd_r.idx] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  assign out_ch.valid             = out_vld_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.handle_index      = out_idx_r;
  assign out_ch.handle_generation = out_gen_r;
  assign out_ch.found_payload     = out_pay_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count_r <= cnt_t'(SLOTS))
    else $error("free count above slot total");

  a_pop_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !slot_used_r[fifo_rd_r.idx])
    else $error("allocate handed out an occupied slot");

  a_release_push: assert property (@(posedge clk) disable iff (!rst_n)
    (rel && !pop) |=> fifo_count_r == $past(fifo_count_r) + cnt_t'(1))
    else $error("release did not return its slot to the free list");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_fire))
    else $error("result appeared without an execute transfer");

endmodule
